// ----- src/sst_pkg.sv -----
// Shared types, widths and helpers of the sample time alignment block.
// Used by the top level sensor_sample_time_sync_interp; depends on nothing.
package sst_pkg;

   localparam int TIME_W   = 40;
   localparam int STATUS_W = 8;
   localparam int LON_W    = 39;
   localparam int LAT_W    = 38;
   localparam int COORD_W  = 32;
   localparam int GAP_W    = 24;
   localparam int VAL_W    = 40;
   localparam int NUM_VALS = 6;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam logic [GAP_W-1:0] GAP_RESET = 24'd200000;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_SYNC = 1'b1;

   // Order of the interpolated values.
   localparam logic [2:0] VAL_LON   = 3'd0;
   localparam logic [2:0] VAL_LAT   = 3'd1;
   localparam logic [2:0] VAL_ALT   = 3'd2;
   localparam logic [2:0] VAL_EAST  = 3'd3;
   localparam logic [2:0] VAL_NORTH = 3'd4;
   localparam logic [2:0] VAL_UP    = 3'd5;

   typedef struct packed {
      logic [TIME_W-1:0]          time_us;
      logic [STATUS_W-1:0]        status;
      logic signed [LON_W-1:0]    lon;
      logic signed [LAT_W-1:0]    lat;
      logic signed [COORD_W-1:0]  alt;
      logic signed [COORD_W-1:0]  east;
      logic signed [COORD_W-1:0]  north;
      logic signed [COORD_W-1:0]  up;
   } entry_type;

   // One coordinate of an entry, sign extended to the common working width.
   function automatic logic signed [VAL_W-1:0] entry_value(entry_type e, logic [2:0] idx);
      logic signed [VAL_W-1:0] v;
      begin
         case (idx)
            VAL_LON:   v = VAL_W'(e.lon);
            VAL_LAT:   v = VAL_W'(e.lat);
            VAL_ALT:   v = VAL_W'(e.alt);
            VAL_EAST:  v = VAL_W'(e.east);
            VAL_NORTH: v = VAL_W'(e.north);
            default:   v = VAL_W'(e.up);
         endcase
         return v;
      end
   endfunction

   function automatic int value_width(logic [2:0] idx);
      begin
         case (idx)
            VAL_LON: return LON_W;
            VAL_LAT: return LAT_W;
            default: return COORD_W;
         endcase
      end
   endfunction

endpackage

// ----- src/sst_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// Used for the sample ring; depends on nothing.
module sst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sensor_sample_time_sync_interp.sv -----
// Sample ring with time alignment by linear interpolation: top level.
// Depends on sst_pkg and sst_ram.
//
// A push word stores one timestamped sample in a ring of DEPTH entries (the
// oldest is dropped and overflow set when full) and answers on the next cycle.
// A sync word drops stale front entries, then interpolates the two front
// entries to the requested time. Each pass over the front pair reads the
// ring in states RD0, RD1 and CHK; the fraction comes from a bit-serial
// restoring divider, and the six coordinates share one 20-bit partial
// product multiplier, each coordinate going through states MUL0 to MUL3.
// One word is in work at a time.
module sensor_sample_time_sync_interp #(
   parameter int DEPTH     = sst_pkg::DEPTH_DEFAULT,
   parameter int FRAC_BITS = sst_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_opcode,
   input  logic [sst_pkg::TIME_W-1:0]           req_in_time,
   input  logic [sst_pkg::STATUS_W-1:0]         req_in_status,
   input  logic signed [sst_pkg::LON_W-1:0]     req_in_lon,
   input  logic signed [sst_pkg::LAT_W-1:0]     req_in_lat,
   input  logic signed [sst_pkg::COORD_W-1:0]   req_in_alt,
   input  logic signed [sst_pkg::COORD_W-1:0]   req_in_east,
   input  logic signed [sst_pkg::COORD_W-1:0]   req_in_north,
   input  logic signed [sst_pkg::COORD_W-1:0]   req_in_up,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_ok,
   output logic                                 rsp_overflow,
   output logic [sst_pkg::TIME_W-1:0]           rsp_out_time,
   output logic [sst_pkg::STATUS_W-1:0]         rsp_out_status,
   output logic signed [sst_pkg::LON_W-1:0]     rsp_out_lon,
   output logic signed [sst_pkg::LAT_W-1:0]     rsp_out_lat,
   output logic signed [sst_pkg::COORD_W-1:0]   rsp_out_alt,
   output logic signed [sst_pkg::COORD_W-1:0]   rsp_out_east,
   output logic signed [sst_pkg::COORD_W-1:0]   rsp_out_north,
   output logic signed [sst_pkg::COORD_W-1:0]   rsp_out_up,
   input  logic                                 csr_we,
   input  logic [sst_pkg::GAP_W-1:0]            csr_wdata
);

   localparam int AW        = $clog2(DEPTH);
   localparam int CW        = $clog2(DEPTH + 1);
   localparam int TW        = sst_pkg::TIME_W;
   localparam int VW        = sst_pkg::VAL_W;
   localparam int MAG_W     = FRAC_BITS + 5;
   localparam int HALF_W    = VW / 2;
   localparam int PP_W      = HALF_W + MAG_W;
   localparam int ACC_W     = VW + MAG_W;
   localparam int RES_W     = ACC_W + 2;
   localparam int DIV_STEPS = TW + FRAC_BITS;
   localparam int DCW       = $clog2(DIV_STEPS + 1);
   localparam int EW        = $bits(sst_pkg::entry_type);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD0, ST_RD1, ST_CHK, ST_DSET, ST_DIV,
      ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3
   } state_type;

   state_type                   state_ff;
   logic [AW-1:0]               head_ff;
   logic [CW-1:0]               count_ff;
   logic [sst_pkg::GAP_W-1:0]   gap_ff;
   logic                        final_ff;
   logic [TW-1:0]               s_ff;
   sst_pkg::entry_type          ent0_ff, ent1_ff;
   logic signed [TW:0]          num_ff, den_ff;
   logic [TW-1:0]               ad_ff;
   logic [TW-1:0]               rem_ff;
   logic [DIV_STEPS-1:0]        dvd_ff;
   logic [MAG_W-1:0]            mag_ff;
   logic                        neg_ff;
   logic [DCW-1:0]              dcnt_ff;
   logic [2:0]                  vidx_ff;
   logic signed [VW-1:0]        vf_ff;
   logic [VW-1:0]               vmag_ff;
   logic                        vneg_ff;
   logic [ACC_W-1:0]            acc_ff;

   logic                        rsp_valid_ff, rsp_ok_ff, rsp_overflow_ff;
   logic [TW-1:0]               rsp_time_ff;
   logic [sst_pkg::STATUS_W-1:0] rsp_status_ff;
   logic signed [sst_pkg::LON_W-1:0]   rsp_lon_ff;
   logic signed [sst_pkg::LAT_W-1:0]   rsp_lat_ff;
   logic signed [sst_pkg::COORD_W-1:0] rsp_alt_ff, rsp_east_ff, rsp_north_ff, rsp_up_ff;

   logic                        ram_we;
   logic [AW-1:0]               ram_waddr, ram_raddr;
   sst_pkg::entry_type          ram_wdata, ram_rdata;

   logic [AW-1:0]               slot0, slot1, slot_cnt;
   logic [CW:0]                 sum1, sumc;
   logic                        req_acc;
   logic [TW:0]                 rem_sh;
   logic                        rem_ge;
   logic signed [TW:0]          d_s0, d_1s;
   logic signed [VW-1:0]        val0, val1;
   logic signed [VW:0]          vdiff;
   logic [HALF_W-1:0]           mhalf;
   logic [PP_W-1:0]             pp;
   logic [ACC_W-1:0]            rounded;
   logic signed [RES_W-1:0]     vres, vhi, vlo, vsat;
   logic [TW-1:0]               an_abs, ad_abs;

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign req_acc   = req_valid && !req_stall;

   // Ring positions relative to the oldest entry.
   assign slot0    = head_ff;
   assign sum1     = (CW + 1)'(head_ff) + (CW + 1)'(1);
   assign sumc     = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign slot1    = (sum1 >= (CW + 1)'(DEPTH)) ? AW'(sum1 - (CW + 1)'(DEPTH)) : AW'(sum1);
   assign slot_cnt = (sumc >= (CW + 1)'(DEPTH)) ? AW'(sumc - (CW + 1)'(DEPTH)) : AW'(sumc);

   assign ram_we    = req_acc && (req_opcode == sst_pkg::OP_PUSH);
   assign ram_waddr = (count_ff == CW'(DEPTH)) ? head_ff : slot_cnt;
   assign ram_wdata = '{time_us: req_in_time, status: req_in_status, lon: req_in_lon,
                        lat: req_in_lat, alt: req_in_alt, east: req_in_east,
                        north: req_in_north, up: req_in_up};
   assign ram_raddr = (state_ff == ST_RD0) ? slot0 : slot1;

   sst_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Gap tests against the freshly read pair.
   assign d_s0 = $signed({1'b0, s_ff}) - $signed({1'b0, ent0_ff.time_us});
   assign d_1s = $signed({1'b0, ram_rdata.time_us}) - $signed({1'b0, s_ff});

   assign an_abs = num_ff[TW] ? TW'(-num_ff) : TW'(num_ff);
   assign ad_abs = den_ff[TW] ? TW'(-den_ff) : TW'(den_ff);

   // Restoring divider step.
   assign rem_sh = {rem_ff, dvd_ff[DIV_STEPS-1]};
   assign rem_ge = rem_sh >= {1'b0, ad_ff};

   // Shared multiplier: low half of the magnitude first, then the high half.
   assign val0    = sst_pkg::entry_value(ent0_ff, vidx_ff);
   assign val1    = sst_pkg::entry_value(ent1_ff, vidx_ff);
   assign vdiff   = $signed({val1[VW-1], val1}) - $signed({val0[VW-1], val0});
   assign mhalf   = (state_ff == ST_MUL1) ? vmag_ff[HALF_W-1:0] : vmag_ff[VW-1:HALF_W];
   assign pp      = PP_W'(mhalf) * PP_W'(mag_ff);
   assign rounded = (acc_ff + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
   assign vres    = (neg_ff != vneg_ff) ? RES_W'(vf_ff) - $signed({2'b00, rounded})
                                        : RES_W'(vf_ff) + $signed({2'b00, rounded});
   assign vhi     = (RES_W'(1) <<< (sst_pkg::value_width(vidx_ff) - 1)) - RES_W'(1);
   assign vlo     = -vhi - RES_W'(1);
   assign vsat    = (vres > vhi) ? vhi : ((vres < vlo) ? vlo : vres);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         gap_ff       <= sst_pkg::GAP_RESET;
         rsp_valid_ff <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            gap_ff <= csr_wdata;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  rsp_time_ff   <= '0;
                  rsp_status_ff <= '0;
                  rsp_lon_ff    <= '0;
                  rsp_lat_ff    <= '0;
                  rsp_alt_ff    <= '0;
                  rsp_east_ff   <= '0;
                  rsp_north_ff  <= '0;
                  rsp_up_ff     <= '0;
                  if (req_opcode == sst_pkg::OP_PUSH) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ok_ff    <= 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        head_ff         <= slot1;
                        rsp_overflow_ff <= 1'b1;
                     end else begin
                        count_ff        <= count_ff + CW'(1);
                        rsp_overflow_ff <= 1'b0;
                     end
                  end else begin
                     s_ff     <= req_in_time;
                     final_ff <= 1'b0;
                     state_ff <= ST_RD0;
                  end
               end
            end
            ST_RD0: begin
               if (count_ff < CW'(2)) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_ok_ff       <= 1'b0;
                  rsp_overflow_ff <= 1'b0;
                  state_ff        <= ST_IDLE;
               end else begin
                  state_ff <= ST_RD1;
               end
            end
            ST_RD1: begin
               ent0_ff  <= ram_rdata;
               state_ff <= ST_CHK;
            end
            ST_CHK: begin
               ent1_ff <= ram_rdata;
               num_ff  <= d_s0;
               den_ff  <= $signed({1'b0, ram_rdata.time_us})
                        - $signed({1'b0, ent0_ff.time_us});
               if (final_ff) begin
                  state_ff <= ST_DSET;
               end else if (ent0_ff.time_us > s_ff) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_ok_ff       <= 1'b0;
                  rsp_overflow_ff <= 1'b0;
                  state_ff        <= ST_IDLE;
               end else if (ram_rdata.time_us < s_ff && count_ff > CW'(2)) begin
                  head_ff  <= slot1;
                  count_ff <= count_ff - CW'(1);
                  state_ff <= ST_RD0;
               end else if (d_s0 > $signed({17'd0, gap_ff})
                            || d_1s > $signed({17'd0, gap_ff})) begin
                  head_ff  <= slot1;
                  count_ff <= count_ff - CW'(1);
                  final_ff <= 1'b1;
                  state_ff <= ST_RD0;
               end else begin
                  state_ff <= ST_DSET;
               end
            end
            ST_DSET: begin
               vidx_ff <= sst_pkg::VAL_LON;
               ad_ff   <= ad_abs;
               rem_ff  <= '0;
               dcnt_ff <= '0;
               dvd_ff  <= {an_abs, FRAC_BITS'(0)};
               if (den_ff == '0 || num_ff == '0) begin
                  mag_ff   <= '0;
                  neg_ff   <= 1'b0;
                  state_ff <= ST_MUL0;
               end else if ({4'd0, an_abs} >= {ad_abs, 4'd0}) begin
                  mag_ff   <= MAG_W'(16) << FRAC_BITS;
                  neg_ff   <= num_ff[TW] != den_ff[TW];
                  state_ff <= ST_MUL0;
               end else begin
                  mag_ff   <= '0;
                  neg_ff   <= num_ff[TW] != den_ff[TW];
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= rem_ge ? TW'(rem_sh - {1'b0, ad_ff}) : TW'(rem_sh);
               mag_ff  <= {mag_ff[MAG_W-2:0], rem_ge};
               dvd_ff  <= dvd_ff << 1;
               dcnt_ff <= dcnt_ff + DCW'(1);
               if (dcnt_ff == DCW'(DIV_STEPS - 1)) begin
                  state_ff <= ST_MUL0;
               end
            end
            ST_MUL0: begin
               vf_ff    <= val0;
               vneg_ff  <= vdiff[VW];
               vmag_ff  <= vdiff[VW] ? VW'(-vdiff) : VW'(vdiff);
               state_ff <= ST_MUL1;
            end
            ST_MUL1: begin
               acc_ff   <= ACC_W'(pp);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               acc_ff   <= acc_ff + (ACC_W'(pp) << HALF_W);
               state_ff <= ST_MUL3;
            end
            ST_MUL3: begin
               case (vidx_ff)
                  sst_pkg::VAL_LON:   rsp_lon_ff   <= sst_pkg::LON_W'(vsat);
                  sst_pkg::VAL_LAT:   rsp_lat_ff   <= sst_pkg::LAT_W'(vsat);
                  sst_pkg::VAL_ALT:   rsp_alt_ff   <= sst_pkg::COORD_W'(vsat);
                  sst_pkg::VAL_EAST:  rsp_east_ff  <= sst_pkg::COORD_W'(vsat);
                  sst_pkg::VAL_NORTH: rsp_north_ff <= sst_pkg::COORD_W'(vsat);
                  default:            rsp_up_ff    <= sst_pkg::COORD_W'(vsat);
               endcase
               if (vidx_ff == sst_pkg::VAL_UP) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_ok_ff       <= 1'b1;
                  rsp_overflow_ff <= 1'b0;
                  rsp_time_ff     <= s_ff;
                  rsp_status_ff   <= ent1_ff.status;
                  state_ff        <= ST_IDLE;
               end else begin
                  vidx_ff  <= vidx_ff + 3'd1;
                  state_ff <= ST_MUL0;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_overflow   = rsp_overflow_ff;
   assign rsp_out_time   = rsp_time_ff;
   assign rsp_out_status = rsp_status_ff;
   assign rsp_out_lon    = rsp_lon_ff;
   assign rsp_out_lat    = rsp_lat_ff;
   assign rsp_out_alt    = rsp_alt_ff;
   assign rsp_out_east   = rsp_east_ff;
   assign rsp_out_north  = rsp_north_ff;
   assign rsp_out_up     = rsp_up_ff;

endmodule
